/* hdl/pfp_pkg.sv */
`default_nettype none

package pfp_pkg;

  localparam logic [7:0]  SYNC_BYTE = 8'h31;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;

  localparam logic [1:0] STAT_IDLE = 2'd0;
  localparam logic [1:0] STAT_GOOD = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  typedef logic [31:0] crc_tab_t [32];

  // CRC of a word holding a single set bit, zero start; the update is linear
  function automatic crc_tab_t crc_cols();
    crc_tab_t    t;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'h1 << i;
      for (int b = 0; b < 32; b++) begin
        c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_COL = crc_cols();

  typedef struct packed {
    logic [1:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [31:0] seq_num;
    logic [31:0] packet_reason;
    logic [7:0]  payload_length;
  } result_t;

endpackage

`default_nettype wire

/* hdl/pfp_crc32.sv */
`default_nettype none

module pfp_crc32 (
  input  wire logic [31:0] crc_in,
  input  wire logic [31:0] word,
  output logic      [31:0] crc_out
);

  logic [31:0] d;

  assign d = crc_in ^ word;

  always_comb begin
    crc_out = '0;
    for (int i = 0; i < 32; i++) begin
      if (d[i]) begin
        crc_out = crc_out ^ pfp_pkg::CRC_COL[i];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/pfp_core.sv */
`default_nettype none

module pfp_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            take,
  input  wire logic [7:0]      in_byte,
  output pfp_pkg::result_t     res
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SEQ     = 3'd1,
    PH_REASON  = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC     = 3'd5
  } phase_t;

  phase_t      phase_r,  phase_nxt;
  logic [1:0]  wbc_r,    wbc_nxt;
  logic [31:0] acc_r,    acc_nxt;
  logic [31:0] crc_r,    crc_nxt;
  logic [31:0] seq_r,    seq_nxt;
  logic [31:0] rsn_r,    rsn_nxt;
  logic [7:0]  len_r,    len_nxt;
  logic [7:0]  prog_r,   prog_nxt;
  logic [31:0] rcrc_r,   rcrc_nxt;

  logic [31:0] byte_sh;
  logic [31:0] acc_ins;
  logic [31:0] crc_upd;
  logic [7:0]  prog_inc;

  assign byte_sh  = {24'd0, in_byte} << {prog_r[1:0], 3'b000};
  assign acc_ins  = acc_r | ({24'd0, in_byte} << {wbc_r, 3'b000});
  assign prog_inc = prog_r + 8'd1;

  pfp_crc32 u_crc (
    .crc_in  (crc_r),
    .word    (acc_ins),
    .crc_out (crc_upd)
  );

  always_comb begin
    phase_nxt = phase_r;
    wbc_nxt   = wbc_r;
    acc_nxt   = acc_r;
    crc_nxt   = crc_r;
    seq_nxt   = seq_r;
    rsn_nxt   = rsn_r;
    len_nxt   = len_r;
    prog_nxt  = prog_r;
    rcrc_nxt  = rcrc_r;
    res       = '0;
    res.status = pfp_pkg::STAT_IDLE;

    // byte into the CRC word; update on a full word
    if (phase_r == PH_SEQ || phase_r == PH_REASON || phase_r == PH_LEN ||
        phase_r == PH_PAYLOAD) begin
      wbc_nxt = wbc_r + 2'd1;
      if (wbc_r == 2'd3) begin
        crc_nxt = crc_upd;
        acc_nxt = '0;
      end else begin
        acc_nxt = acc_ins;
      end
    end

    unique case (phase_r)
      PH_SEQ: begin
        seq_nxt  = seq_r | byte_sh;
        prog_nxt = prog_inc;
        if (prog_inc >= 8'd4) begin
          prog_nxt  = '0;
          phase_nxt = PH_REASON;
        end
      end
      PH_REASON: begin
        rsn_nxt  = rsn_r | byte_sh;
        prog_nxt = prog_inc;
        if (prog_inc >= 8'd4) begin
          prog_nxt  = '0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        len_nxt  = in_byte;
        prog_nxt = '0;
        if (in_byte == 8'd0) begin
          crc_nxt   = crc_upd;
          acc_nxt   = '0;
          wbc_nxt   = '0;
          phase_nxt = PH_CRC;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = in_byte;
        res.payload_index = prog_r;
        prog_nxt = prog_inc;
        if (prog_inc >= len_r) begin
          crc_nxt   = crc_upd;
          acc_nxt   = '0;
          wbc_nxt   = '0;
          prog_nxt  = '0;
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        rcrc_nxt = rcrc_r | byte_sh;
        prog_nxt = prog_inc;
        if (prog_inc >= 8'd4) begin
          res.status = (rcrc_nxt == crc_r) ? pfp_pkg::STAT_GOOD : pfp_pkg::STAT_BAD;
          prog_nxt   = '0;
          phase_nxt  = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (in_byte == pfp_pkg::SYNC_BYTE) begin
          crc_nxt   = pfp_pkg::CRC_INIT;
          acc_nxt   = {24'd0, in_byte};
          wbc_nxt   = 2'd1;
          seq_nxt   = '0;
          rsn_nxt   = '0;
          len_nxt   = '0;
          prog_nxt  = '0;
          rcrc_nxt  = '0;
          phase_nxt = PH_SEQ;
        end
      end
    endcase

    res.seq_num        = seq_nxt;
    res.packet_reason  = rsn_nxt;
    res.payload_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      wbc_r   <= '0;
      acc_r   <= '0;
      crc_r   <= pfp_pkg::CRC_INIT;
      seq_r   <= '0;
      rsn_r   <= '0;
      len_r   <= '0;
      prog_r  <= '0;
      rcrc_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      wbc_r   <= wbc_nxt;
      acc_r   <= acc_nxt;
      crc_r   <= crc_nxt;
      seq_r   <= seq_nxt;
      rsn_r   <= rsn_nxt;
      len_r   <= len_nxt;
      prog_r  <= prog_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/packet_frame_parser_crc32.sv */
`default_nettype none

// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_byte
// out_     output     out_valid/out_stall status, payload fields, header fields
//
// One item per cycle unless stalled; its result appears in the next cycle.
// Parser state and the CRC-32 word update sit in front of one output register.
// rst_n is synchronous; reset returns the parser to sync hunting.
// The input stalls only while the output register holds an untaken result
// and out_stall is high.

module packet_frame_parser_crc32 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_index,
  output logic [31:0]      out_seq_num,
  output logic [31:0]      out_packet_reason,
  output logic [7:0]       out_payload_length
);

  logic             take;
  logic             out_valid_r;
  pfp_pkg::result_t res;
  pfp_pkg::result_t res_r;

  assign in_stall = out_valid_r & out_stall;
  assign take     = in_valid & ~in_stall;

  pfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_payload_valid   = res_r.payload_valid;
  assign out_payload_byte    = res_r.payload_byte;
  assign out_payload_index   = res_r.payload_index;
  assign out_seq_num         = res_r.seq_num;
  assign out_packet_reason   = res_r.packet_reason;
  assign out_payload_length  = res_r.payload_length;

endmodule

`default_nettype wire

/* hdl/pfp_checker.sv */
`default_nettype none

module pfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic        out_payload_valid,
  input wire logic [7:0]  out_payload_byte,
  input wire logic [7:0]  out_payload_index
);

  // every accepted item yields a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == pfp_pkg::STAT_IDLE || out_status == pfp_pkg::STAT_GOOD ||
      out_status == pfp_pkg::STAT_BAD)
    else $error("undefined status code");

  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'd0 &&
      out_payload_index == 8'd0)
    else $error("payload fields set without payload_valid");

  // the verdict comes on a CRC byte, never on a payload byte
  a_verdict_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pfp_pkg::STAT_IDLE |-> !out_payload_valid)
    else $error("verdict on a payload item");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_payload_byte))
    else $error("stalled result changed");

endmodule

bind packet_frame_parser_crc32 pfp_checker u_pfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_payload_valid (out_payload_valid),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index)
);

`default_nettype wire
